// File: rtl/fpss_pkg.sv
// fpss_pkg: shared constants and types for the five-point stencil sweep
// no dependencies; imported by every module of the block
`default_nettype none

package fpss_pkg;

    localparam int DEF_MAX_SIZE = 64;   // deepest column the memories hold
    localparam int VAL_W        = 32;   // signed q16.16 cell value
    localparam int SUM_W        = 35;   // exact stencil sum, q19.16
    localparam int GRID_W       = 7;    // grid_size register width
    localparam int POS_W        = 6;    // reported row and column width
    localparam int TDATA_W      = 48;   // value, row, col, padded to bytes
    localparam int GRID_MIN     = 3;
    localparam int GRID_RESET   = 10;

    // where the item sits in the grid, worked out at accept time
    typedef struct packed {
        logic first_col;   // column 0: stored only
        logic last_col;    // column n-1: releases itself as well
        logic last_row;    // row n-1
        logic border;      // released cell passes through unchanged
    } pos_flags_t;

endpackage

`default_nettype wire

// File: rtl/fpss_seq.sv
// fpss_seq: grid size register and row/column counters of the sweep
// depends on fpss_pkg
`default_nettype none

module fpss_seq #(
    parameter int MAX_SIZE = fpss_pkg::DEF_MAX_SIZE
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [fpss_pkg::GRID_W-1:0]   cfg_data,
    input  wire logic                          item_acc,
    output logic [$clog2(MAX_SIZE)-1:0]        pos_row,
    output logic [$clog2(MAX_SIZE)-1:0]        pos_col,
    output logic [$clog2(MAX_SIZE)-1:0]        next_row,
    output fpss_pkg::pos_flags_t               pos_flags
);
    import fpss_pkg::*;

    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int RST_LAST = ((GRID_RESET > MAX_SIZE) ? MAX_SIZE : GRID_RESET) - 1;

    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic             at_last_row;

    // side saturated to 3..MAX_SIZE, kept as the last index
    always_comb begin
        if (int'(cfg_data) < GRID_MIN) begin
            last_next = IDX_W'(GRID_MIN - 1);
        end else if (int'(cfg_data) > MAX_SIZE) begin
            last_next = IDX_W'(MAX_SIZE - 1);
        end else begin
            last_next = IDX_W'(cfg_data - GRID_W'(1));
        end
    end

    assign at_last_row = (row_reg == last_reg);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we) begin
            row_next = '0;
            col_next = '0;
        end else if (item_acc) begin
            if (at_last_row) begin
                row_next = '0;
                col_next = (col_reg == last_reg) ? '0 : col_reg + IDX_W'(1);
            end else begin
                row_next = row_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= IDX_W'(RST_LAST);
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            if (cfg_we) begin
                last_reg <= last_next;
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign pos_row  = row_reg;
    assign pos_col  = col_reg;
    assign next_row = at_last_row ? '0 : row_reg + IDX_W'(1);

    assign pos_flags.first_col = (col_reg == '0);
    assign pos_flags.last_col  = (col_reg == last_reg);
    assign pos_flags.last_row  = at_last_row;
    assign pos_flags.border    = (col_reg == IDX_W'(1)) || (row_reg == '0) || at_last_row;

endmodule

`default_nettype wire

// File: rtl/fpss_colmem.sv
// fpss_colmem: original-column and updated-column memories, registered reads
// depends on fpss_pkg
`default_nettype none

module fpss_colmem #(
    parameter int MAX_SIZE = fpss_pkg::DEF_MAX_SIZE
) (
    input  wire logic                              aclk,
    input  wire logic                              item_acc,
    input  wire logic [$clog2(MAX_SIZE)-1:0]       acc_row,
    input  wire logic [$clog2(MAX_SIZE)-1:0]       acc_next_row,
    input  wire logic [fpss_pkg::VAL_W-1:0]        acc_value,
    input  wire logic                              upd_we,
    input  wire logic [$clog2(MAX_SIZE)-1:0]       upd_addr,
    input  wire logic [fpss_pkg::VAL_W-1:0]        upd_wdata,
    output logic [fpss_pkg::VAL_W-1:0]             orig_q,
    output logic [fpss_pkg::VAL_W-1:0]             upd_q
);
    import fpss_pkg::*;

    logic [VAL_W-1:0] orig_mem [MAX_SIZE];
    logic [VAL_W-1:0] upd_mem  [MAX_SIZE];

    // the row below is read while this row is overwritten; addresses never meet
    always_ff @(posedge aclk) begin
        if (item_acc) begin
            orig_mem[acc_row] <= acc_value;
            orig_q            <= orig_mem[acc_next_row];
        end
    end

    // left neighbour read at accept; write-back always targets another row
    always_ff @(posedge aclk) begin
        if (item_acc) begin
            upd_q <= upd_mem[acc_row];
        end
        if (upd_we) begin
            upd_mem[upd_addr] <= upd_wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpss_stencil.sv
// fpss_stencil: work stage, stencil arithmetic and result register
// depends on fpss_pkg; fed by fpss_seq and fpss_colmem
`default_nettype none

module fpss_stencil #(
    parameter int MAX_SIZE = fpss_pkg::DEF_MAX_SIZE
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              item_acc,
    input  wire logic [fpss_pkg::VAL_W-1:0]        acc_value,
    input  wire logic [$clog2(MAX_SIZE)-1:0]       acc_row,
    input  wire logic [$clog2(MAX_SIZE)-1:0]       acc_col,
    input  wire fpss_pkg::pos_flags_t              acc_flags,
    input  wire logic [fpss_pkg::VAL_W-1:0]        orig_q,
    input  wire logic [fpss_pkg::VAL_W-1:0]        upd_q,
    output logic                                   stage_free,
    output logic                                   upd_we,
    output logic [$clog2(MAX_SIZE)-1:0]            upd_addr,
    output logic [fpss_pkg::VAL_W-1:0]             upd_wdata,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [fpss_pkg::VAL_W-1:0]             out_value,
    output logic [fpss_pkg::POS_W-1:0]             out_row,
    output logic [fpss_pkg::POS_W-1:0]             out_col,
    output logic                                   out_last,
    output logic                                   out_frame
);
    import fpss_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIZE);

    // work stage
    logic                    b_valid_reg, b_valid_next;
    logic                    b_phase_reg, b_phase_next;
    logic signed [VAL_W-1:0] b_x_reg;
    logic [IDX_W-1:0]        b_row_reg;
    logic [IDX_W-1:0]        b_col_reg;
    pos_flags_t              b_flags_reg;

    // centre comes from the previous item's look-ahead read
    logic signed [VAL_W-1:0] centre_reg;
    logic signed [VAL_W-1:0] above_reg;

    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_value_reg;
    logic [POS_W-1:0]        out_row_reg;
    logic [POS_W-1:0]        out_col_reg;
    logic                    out_last_reg;
    logic                    out_frame_reg;

    logic                    out_free;
    logic                    emit;
    logic                    b_done;
    logic signed [SUM_W-1:0] sum;
    logic [VAL_W-1:0]        swept;
    logic [VAL_W-1:0]        emit_value;
    logic [IDX_W-1:0]        emit_col;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = b_valid_reg && !b_flags_reg.first_col && out_free;
    assign b_done     = b_valid_reg && (b_flags_reg.first_col ||
                        (out_free && (b_phase_reg || !b_flags_reg.last_col)));
    assign stage_free = !b_valid_reg || b_done;

    // exact sum, floored once by the arithmetic shift of three
    assign sum = (SUM_W'(centre_reg) <<< 2) + SUM_W'(above_reg)
               + SUM_W'(signed'(orig_q)) + SUM_W'(signed'(upd_q)) + SUM_W'(b_x_reg);
    assign swept = b_flags_reg.border ? centre_reg : sum[SUM_W-1:3];

    assign emit_value = b_phase_reg ? b_x_reg : swept;
    assign emit_col   = b_phase_reg ? b_col_reg : b_col_reg - IDX_W'(1);

    assign upd_we    = emit && !b_phase_reg;
    assign upd_addr  = b_row_reg;
    assign upd_wdata = swept;

    always_comb begin
        b_valid_next = b_valid_reg;
        b_phase_next = b_phase_reg;
        if (item_acc) begin
            b_valid_next = 1'b1;
            b_phase_next = 1'b0;
        end else if (b_done) begin
            b_valid_next = 1'b0;
        end else if (emit && !b_phase_reg && b_flags_reg.last_col) begin
            b_phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            b_phase_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            above_reg     <= '0;
        end else begin
            b_valid_reg <= b_valid_next;
            b_phase_reg <= b_phase_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (upd_we) begin
                above_reg <= swept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_acc) begin
            b_x_reg     <= signed'(acc_value);
            b_row_reg   <= acc_row;
            b_col_reg   <= acc_col;
            b_flags_reg <= acc_flags;
        end
        if (b_done) begin
            centre_reg <= signed'(orig_q);
        end
        if (emit) begin
            out_value_reg <= emit_value;
            out_row_reg   <= POS_W'(b_row_reg);
            out_col_reg   <= POS_W'(emit_col);
            out_last_reg  <= b_phase_reg || !b_flags_reg.last_col;
            out_frame_reg <= b_phase_reg && b_flags_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;
    assign out_frame = out_frame_reg;

endmodule

`default_nettype wire

// File: rtl/five_point_stencil_sweep_top.sv
// five_point_stencil_sweep_top: in-place gauss-seidel five-point sweep, streaming
// depends on fpss_pkg, fpss_seq, fpss_colmem, fpss_stencil
//
//   channel   direction  handshake             payload
//   s_        in         s_tvalid / s_tready   cell_value
//   m_        out        m_tvalid / m_tready   result_value, row, col; run_end, frame_end
//   cfg_      in         cfg_valid / cfg_ready grid_size (always ready)
//
// one cell per cycle is accepted while m_ keeps up; a cell in the last column releases
// two results, so the next cell is taken only as the second goes into the output register
// a result goes from the work stage into the output register onto m_, a second one after it
// the memory look-ahead read of the next row supplies the next item's centre
// while a result waits unread a releasing item stays in the work stage, then s_tready drops
// no clearing pass after reset; a grid_size write restarts the frame
`default_nettype none

module five_point_stencil_sweep_top #(
    parameter int MAX_SIZE = fpss_pkg::DEF_MAX_SIZE
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fpss_pkg::VAL_W-1:0]      s_tdata,   // [31:0] cell_value
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fpss_pkg::TDATA_W-1:0]         m_tdata,   // [31:0] result_value,
                                                            // [37:32] row, [43:38] col
    output logic                                 m_tlast,   // run_end
    output logic                                 m_tuser,   // frame_end
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fpss_pkg::GRID_W-1:0]     cfg_data   // grid_size
);
    import fpss_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIZE);

    logic             item_acc;
    logic             stage_free;
    logic [IDX_W-1:0] pos_row;
    logic [IDX_W-1:0] pos_col;
    logic [IDX_W-1:0] next_row;
    pos_flags_t       pos_flags;
    logic [VAL_W-1:0] orig_q;
    logic [VAL_W-1:0] upd_q;
    logic             upd_we;
    logic [IDX_W-1:0] upd_addr;
    logic [VAL_W-1:0] upd_wdata;
    logic [VAL_W-1:0] out_value;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;

    assign cfg_ready = 1'b1;
    assign s_tready  = stage_free;
    assign item_acc  = s_tvalid && stage_free;

    fpss_seq #(
        .MAX_SIZE (MAX_SIZE)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .item_acc  (item_acc),
        .pos_row   (pos_row),
        .pos_col   (pos_col),
        .next_row  (next_row),
        .pos_flags (pos_flags)
    );

    fpss_colmem #(
        .MAX_SIZE (MAX_SIZE)
    ) u_colmem (
        .aclk         (aclk),
        .item_acc     (item_acc),
        .acc_row      (pos_row),
        .acc_next_row (next_row),
        .acc_value    (s_tdata),
        .upd_we       (upd_we),
        .upd_addr     (upd_addr),
        .upd_wdata    (upd_wdata),
        .orig_q       (orig_q),
        .upd_q        (upd_q)
    );

    fpss_stencil #(
        .MAX_SIZE (MAX_SIZE)
    ) u_stencil (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_acc   (item_acc),
        .acc_value  (s_tdata),
        .acc_row    (pos_row),
        .acc_col    (pos_col),
        .acc_flags  (pos_flags),
        .orig_q     (orig_q),
        .upd_q      (upd_q),
        .stage_free (stage_free),
        .upd_we     (upd_we),
        .upd_addr   (upd_addr),
        .upd_wdata  (upd_wdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_last   (m_tlast),
        .out_frame  (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - VAL_W - 2*POS_W){1'b0}}, out_col, out_row, out_value};

endmodule

`default_nettype wire

// File: test/stencil_sweep_checker.sv
`timescale 1ns / 100ps
// stencil_sweep_checker: watches the cell, result and grid-size channels of the sweep,
// keeps its own copy of the columns and predicts every swept cell, then compares in order
// depends on fpss_pkg
module stencil_sweep_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [fpss_pkg::VAL_W-1:0]   s_tdata,   // [31:0] cell_value
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [fpss_pkg::TDATA_W-1:0] m_tdata,   // [31:0] value, [37:32] row,
                                                         // [43:38] col
    input  wire logic                         m_tlast,   // run_end
    input  wire logic                         m_tuser,   // frame_end
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [fpss_pkg::GRID_W-1:0]  cfg_data,  // grid_size
    output int                                results_due,
    output int                                error_count
);
    import fpss_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_end;
        logic             frame_end;
    } swept_cell_t;

    swept_cell_t       swept_q[$];
    logic [VAL_W-1:0]  original_col [DEF_MAX_SIZE];
    logic [VAL_W-1:0]  swept_col [DEF_MAX_SIZE];
    logic [VAL_W-1:0]  swept_above;
    logic [GRID_W-1:0] grid_reg;
    int unsigned       next_row;
    int unsigned       next_col;

    initial begin
        error_count = 0;
        results_due = 0;
    end

    function automatic int unsigned grid_side(input logic [GRID_W-1:0] g);
        if (g < GRID_MIN) return GRID_MIN;
        if (g > DEF_MAX_SIZE) return DEF_MAX_SIZE;
        return 32'(g);
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(input logic [VAL_W-1:0] v);
        return {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};
    endfunction

    task automatic sweep_cell(input logic [VAL_W-1:0] x);
        int unsigned             n;
        int unsigned             r;
        int unsigned             c;
        logic [VAL_W-1:0]        centre;
        logic [VAL_W-1:0]        res;
        logic signed [SUM_W-1:0] total;
        swept_cell_t             item;
        n = grid_side(grid_reg);
        r = (next_row >= n) ? 0 : next_row;
        c = (next_col >= n) ? 0 : next_col;
        if (c == 0) begin
            original_col[r] = x;
        end else begin
            centre = original_col[r];
            if (c == 1 || r == 0 || r == n - 1) begin
                res = centre;
            end else begin
                // up and left are already swept, down and right still original
                total = (widen(centre) <<< 2) + widen(swept_above)
                      + widen(original_col[r + 1]) + widen(swept_col[r]) + widen(x);
                res = total[SUM_W-1:3];   // floor of the divide by eight
            end
            swept_col[r]    = res;
            swept_above     = res;
            original_col[r] = x;
            item = '{res, POS_W'(r), POS_W'(c - 1), c != n - 1, 1'b0};
            swept_q = {swept_q, item};
            if (c == n - 1) begin
                // last column is a border, so it goes out as it came in
                item = '{x, POS_W'(r), POS_W'(c), 1'b1, r == n - 1};
                swept_q = {swept_q, item};
            end
        end
        r++;
        if (r >= n) begin
            r = 0;
            c++;
            if (c >= n) c = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic check_result();
        swept_cell_t want;
        if (swept_q.size() == 0) begin
            report_mismatch("result with none due", 64'(m_tdata), 64'd0);
            return;
        end
        want = swept_q.pop_front();
        if (m_tdata[VAL_W-1:0] !== want.value)
            report_mismatch("result_value", 64'(m_tdata[VAL_W-1:0]), 64'(want.value));
        if (m_tdata[VAL_W +: POS_W] !== want.row)
            report_mismatch("row", 64'(m_tdata[VAL_W +: POS_W]), 64'(want.row));
        if (m_tdata[VAL_W + POS_W +: POS_W] !== want.col)
            report_mismatch("col", 64'(m_tdata[VAL_W + POS_W +: POS_W]), 64'(want.col));
        if (m_tlast !== want.run_end)
            report_mismatch("run_end", 64'(m_tlast), 64'(want.run_end));
        if (m_tuser !== want.frame_end)
            report_mismatch("frame_end", 64'(m_tuser), 64'(want.frame_end));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg    = GRID_W'(GRID_RESET);
            next_row    = 0;
            next_col    = 0;
            swept_above = '0;
            swept_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                grid_reg = cfg_data;
                next_row = 0;
                next_col = 0;
            end
            if (s_tvalid && s_tready) sweep_cell(s_tdata);
            if (m_tvalid && m_tready) check_result();
        end
        results_due <= swept_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// testbench: feeds cells and grid-size writes to five_point_stencil_sweep_top with random
// stalls on both channels; the checker beside the block predicts and compares every item
// depends on fpss_pkg, the block's rtl and stencil_sweep_checker
module testbench;
    import fpss_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CELLS = 580;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 900;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [GRID_W-1:0]  cfg_data  = '0;
    int                 results_due;
    int                 error_count;
    int                 cells_sent = 0;
    int                 cycles     = 0;
    int                 hold_left  = 0;
    logic               hold_done  = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    five_point_stencil_sweep_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stencil_sweep_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .results_due (results_due),
        .error_count (error_count)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // random breaks for either side, but a stretch of the run where neither side takes a break
    function automatic logic take_break();
        if (cells_sent >= CALM_FROM && cells_sent < CALM_TO) return 1'b0;
        return $urandom_range(0, 99) < 14;
    endfunction

    // result side: random stalls plus one long hold that backs the block up
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && cells_sent >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= !take_break();
        end
    end

    task automatic send_cell(input logic [VAL_W-1:0] v);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cells_sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_cell();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return VAL_W'($urandom_range(0, 511)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_cells(input int count);
        repeat (count) send_cell(pick_cell());
    endtask

    // only written with the block drained; column-0 cells leave no result to wait on
    task automatic write_grid(input logic [GRID_W-1:0] g);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        logic [GRID_W-1:0] g;
        int                count;
        case ($urandom_range(0, 9))
            0: begin
                g     = GRID_W'($urandom_range(0, GRID_MIN - 1));
                count = GRID_MIN * GRID_MIN * $urandom_range(1, 3);
            end
            1: begin
                g     = GRID_W'($urandom_range(DEF_MAX_SIZE + 1, (1 << GRID_W) - 1));
                count = $urandom_range(DEF_MAX_SIZE, 3 * DEF_MAX_SIZE);
            end
            2: begin
                g     = GRID_W'($urandom_range(9, 20));
                count = g * g;
            end
            default: begin
                g     = GRID_W'($urandom_range(GRID_MIN, 8));
                count = g * g * $urandom_range(1, 3);
            end
        endcase
        // some phases stop mid-frame so the next write restarts it
        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
        write_grid(g);
        run_cells(count);
    endtask

    initial begin
        int random_from;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size: column 0 of extremes, then the first cell of column 1
        for (int k = 0; k < 11; k++) send_cell(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        // zero saturates to the smallest grid and restarts the frame mid-way
        write_grid('0);
        repeat (9) send_cell(32'h7FFF_FFFF);
        repeat (9) send_cell(32'h8000_0000);

        random_from = cells_sent;
        while (cells_sent - random_from < RANDOM_CELLS) random_phase();

        // an oversized size saturates to the largest side; a few columns of it
        write_grid('1);
        run_cells(3 * DEF_MAX_SIZE + 5);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/fpss_pkg.sv
rtl/fpss_seq.sv
rtl/fpss_colmem.sv
rtl/fpss_stencil.sv
rtl/five_point_stencil_sweep_top.sv
test/stencil_sweep_checker.sv
test/testbench.sv
